### src/fpd_pkg.sv
// Shared types, constants and segment tables for the display frame encoder.
package fpd_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'hAA;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;
  localparam logic [7:0] CSUM_BIAS  = 8'hCC;
  localparam logic [7:0] BLANK_SEG  = 8'hFF;
  localparam int         FRAME_LEN  = 7;
  localparam int         SPIN_STEPS = 14;
  localparam int         PCT_SCALE  = 100;
  localparam int         DONE_W     = 16;
  localparam int         PROD_W     = 23;
  localparam int         DIV_STEPS  = PROD_W;
  localparam int         CNT_W      = $clog2(DIV_STEPS);
  localparam int         IDX_W      = $clog2(FRAME_LEN);

  // ceil(2^30 / 100): exact quotient by 100 for any PROD_W-bit value
  localparam int                 RECIP_SH  = 30;
  localparam int                 RECIP_W   = 24;
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

  localparam logic FUNC_TEXT = 1'b0;
  localparam logic FUNC_PCT  = 1'b1;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic mod_mul;
    logic mod_sub;
    logic build;
    logic send_adv;
  } cmd_t;

  typedef struct packed {
    logic is_pct;
    logic div_last;
    logic last_byte;
  } stat_t;

  function automatic logic [7:0] seg_of(input logic [7:0] ch);
    logic [7:0] s;
    case (ch)
      "0": s = 8'hC0; "1": s = 8'hF9; "2": s = 8'hA4; "3": s = 8'hB0;
      "4": s = 8'h99; "5": s = 8'h92; "6": s = 8'h82; "7": s = 8'hD8;
      "8": s = 8'h80; "9": s = 8'h98;
      "A": s = 8'h88; "B": s = 8'h80; "C": s = 8'hC6; "D": s = 8'hA1;
      "E": s = 8'h86; "F": s = 8'h8E; "G": s = 8'h82; "H": s = 8'h89;
      "I": s = 8'hF9; "J": s = 8'hF0; "L": s = 8'hC7; "N": s = 8'hAB;
      "O": s = 8'hC0; "P": s = 8'h8C; "Q": s = 8'h98; "R": s = 8'h88;
      "S": s = 8'h92; "T": s = 8'hF8; "U": s = 8'hC1; "Y": s = 8'h91;
      "a": s = 8'h88; "b": s = 8'h83; "c": s = 8'hA7; "d": s = 8'hA1;
      "e": s = 8'h86; "f": s = 8'h8E; "g": s = 8'h98; "h": s = 8'h8B;
      "i": s = 8'hF9; "j": s = 8'hF0; "l": s = 8'hC7; "n": s = 8'hAB;
      "o": s = 8'hA3; "p": s = 8'h8C; "q": s = 8'h98; "r": s = 8'hAF;
      "s": s = 8'h92; "t": s = 8'h87; "u": s = 8'hE3; "y": s = 8'h91;
      "-": s = 8'hBF; "_": s = 8'hF7;
      default: s = BLANK_SEG;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    return seg_of(8'("0") + {4'd0, d});
  endfunction

  function automatic logic [7:0] spin_left(input logic [3:0] idx);
    logic [7:0] s;
    case (idx)
      4'd1:  s = 8'hEF; 4'd2:  s = 8'hBF; 4'd3:  s = 8'hFD; 4'd4:  s = 8'hFE;
      4'd5:  s = 8'hDF; 4'd6:  s = 8'hBF; 4'd7:  s = 8'hFB; 4'd8:  s = 8'hF7;
      4'd9:  s = 8'hEF; 4'd10: s = 8'hDF; 4'd11: s = 8'hFE; 4'd12: s = 8'hFD;
      4'd13: s = 8'hFB;
      default: s = 8'hF7;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] spin_right(input logic [3:0] idx);
    logic [7:0] s;
    case (idx)
      4'd1:  s = 8'hFB; 4'd2:  s = 8'hBF; 4'd3:  s = 8'hDF; 4'd4:  s = 8'hFE;
      4'd5:  s = 8'hFD; 4'd6:  s = 8'hBF; 4'd7:  s = 8'hEF; 4'd8:  s = 8'hF7;
      4'd9:  s = 8'hFB; 4'd10: s = 8'hFD; 4'd11: s = 8'hFE; 4'd12: s = 8'hDF;
      4'd13: s = 8'hEF;
      default: s = 8'hF7;
    endcase
    return s;
  endfunction

endpackage

### src/front_panel_display_frame_encoder.sv
// Top level of the front-panel display frame encoder.
//   channel | direction | beat
//   in_     | input     | func, char0..char3, done_units, total_units
//   out_    | output    | frame_byte, frame_end (one of seven bytes per frame)
// Text frame: capture, a function check, build, then seven output beats.
// Percent frame: adds a 23-step shift-subtract division (done*100/total), then
// a multiply step and a subtract step for mod 100.
// The seven beats stall while out_ready is low.
// One frame at a time; input is taken only when the previous frame is fully sent.
// Synchronous active-low reset clears the controller, byte index and spinner.
module front_panel_display_frame_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_char0,
  input  logic [7:0]  in_char1,
  input  logic [7:0]  in_char2,
  input  logic [7:0]  in_char3,
  input  logic [15:0] in_done_units,
  input  logic [15:0] in_total_units,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_byte,
  output logic        out_frame_end
);

  fpd_pkg::cmd_t  cmd;
  fpd_pkg::stat_t stat;

  fpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fpd_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_func        (in_func),
    .in_char0       (in_char0),
    .in_char1       (in_char1),
    .in_char2       (in_char2),
    .in_char3       (in_char3),
    .in_done_units  (in_done_units),
    .in_total_units (in_total_units),
    .out_frame_byte (out_frame_byte),
    .out_frame_end  (out_frame_end)
  );

endmodule

### src/fpd_ctrl.sv
// Controller state machine sequencing capture, division, frame build and send.
module fpd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  fpd_pkg::stat_t stat,
  output fpd_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_INIT1 = 7'b0000010,
    ST_DIV1  = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_SUB   = 7'b0010000,
    ST_BUILD = 7'b0100000,
    ST_SEND  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_SEND);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_INIT1;
        end
      end
      ST_INIT1: begin
        if (stat.is_pct) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV1;
        end else begin
          state_nxt = ST_BUILD;
        end
      end
      ST_DIV1: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mod_mul = 1'b1;
        state_nxt   = ST_SUB;
      end
      ST_SUB: begin
        cmd.mod_sub = 1'b1;
        state_nxt   = ST_BUILD;
      end
      ST_BUILD: begin
        cmd.build = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready) begin
          cmd.send_adv = 1'b1;
          if (stat.last_byte) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/fpd_datapath.sv
// Datapath: input capture, shift-subtract divider, mod 100, segment build and byte mux.
module fpd_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fpd_pkg::cmd_t            cmd,
  output fpd_pkg::stat_t           stat,
  input  logic                     in_func,
  input  logic [7:0]               in_char0,
  input  logic [7:0]               in_char1,
  input  logic [7:0]               in_char2,
  input  logic [7:0]               in_char3,
  input  logic [15:0]              in_done_units,
  input  logic [15:0]              in_total_units,
  output logic [7:0]               out_frame_byte,
  output logic                     out_frame_end
);

  localparam int PW = fpd_pkg::PROD_W;
  localparam int DW = fpd_pkg::DONE_W;
  localparam int MW = fpd_pkg::PROD_W + fpd_pkg::RECIP_W;

  logic                         func_r;
  logic [7:0]                   ch_r [4];
  logic [DW-1:0]                done_r, total_r;
  logic [DW-1:0]                dvsr_r;
  logic [DW-1:0]                rem_r, rem_nxt;
  logic [PW-1:0]                q_r, q_nxt;
  logic [fpd_pkg::CNT_W-1:0]    cnt_r;
  logic                         small_r;
  logic [6:0]                   hund_lo_r;
  logic [6:0]                   pct_lo_r;
  logic [6:0]                   r100_r;
  logic [3:0]                   spin_r;
  logic [7:0]                   seg_r [4];
  logic [7:0]                   csum_r;
  logic [fpd_pkg::IDX_W-1:0]    idx_r;

  logic [DW:0]     shifted;
  logic [DW+1:0]   diff;
  logic [PW-1:0]   pct;
  logic [PW-1:0]   prod;
  logic [MW-1:0]   recip_prod;
  logic [6:0]      hund_lo;
  logic [3:0]      spin_use;
  logic [6:0]      r100;
  logic [14:0]     tens_mul;
  logic [3:0]      tens, ones;
  logic [7:0]      seg_nxt [4];
  logic [7:0]      csum_nxt;
  logic [3:0]      ended;

  assign stat.is_pct    = (func_r == fpd_pkg::FUNC_PCT);
  assign stat.div_last  = (cnt_r == fpd_pkg::CNT_W'(fpd_pkg::DIV_STEPS - 1));
  assign stat.last_byte = (idx_r == fpd_pkg::IDX_W'(fpd_pkg::FRAME_LEN - 1));

  assign prod    = PW'(done_r) * PW'(fpd_pkg::PCT_SCALE);
  assign pct     = (total_r == '0) ? '0 : q_r;
  assign shifted = {rem_r, q_r[PW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvsr_r};

  always_comb begin
    if (!diff[DW+1]) begin
      rem_nxt = diff[DW-1:0];
      q_nxt   = {q_r[PW-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DW-1:0];
      q_nxt   = {q_r[PW-2:0], 1'b0};
    end
  end

  assign recip_prod = MW'(pct) * MW'(fpd_pkg::RECIP_100);
  assign hund_lo    = 7'(recip_prod >> fpd_pkg::RECIP_SH);

  assign spin_use = (spin_r < 4'(fpd_pkg::SPIN_STEPS)) ? spin_r : 4'd0;
  assign r100     = r100_r;
  assign tens_mul = {8'd0, r100} * 15'd205;
  assign tens     = tens_mul[14:11];
  assign ones     = 4'(r100 - ({tens, 3'b000} + {2'b00, tens, 1'b0}));

  always_comb begin
    ended[0] = (ch_r[0] == 8'd0);
    ended[1] = ended[0] | (ch_r[1] == 8'd0);
    ended[2] = ended[1] | (ch_r[2] == 8'd0);
    ended[3] = ended[2] | (ch_r[3] == 8'd0);
    if (func_r == fpd_pkg::FUNC_PCT) begin
      seg_nxt[0] = fpd_pkg::spin_left(spin_use);
      seg_nxt[1] = small_r ? fpd_pkg::BLANK_SEG : fpd_pkg::digit_seg(tens);
      seg_nxt[2] = fpd_pkg::digit_seg(ones);
      seg_nxt[3] = fpd_pkg::spin_right(spin_use);
    end else begin
      for (int i = 0; i < 4; i++) begin
        seg_nxt[i] = ended[i] ? fpd_pkg::BLANK_SEG : fpd_pkg::seg_of(ch_r[i]);
      end
    end
    csum_nxt = fpd_pkg::HDR_BYTE + fpd_pkg::ZERO_BYTE + fpd_pkg::CSUM_BIAS
             + seg_nxt[0] + seg_nxt[1] + seg_nxt[2] + seg_nxt[3];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      ch_r[0] <= in_char0;
      ch_r[1] <= in_char1;
      ch_r[2] <= in_char2;
      ch_r[3] <= in_char3;
      done_r  <= in_done_units;
      total_r <= in_total_units;
    end
    if (cmd.div_init) begin
      rem_r  <= '0;
      cnt_r  <= '0;
      q_r    <= prod;
      dvsr_r <= total_r;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r + fpd_pkg::CNT_W'(1);
    end
    if (cmd.mod_mul) begin
      hund_lo_r <= hund_lo;
      pct_lo_r  <= pct[6:0];
      small_r   <= (pct < PW'(10));
    end
    if (cmd.mod_sub) begin
      r100_r <= pct_lo_r - ({hund_lo_r[0], 6'd0} + {hund_lo_r[1:0], 5'd0}
                            + {hund_lo_r[4:0], 2'd0});
    end
    if (cmd.build) begin
      for (int i = 0; i < 4; i++) begin
        seg_r[i] <= seg_nxt[i];
      end
      csum_r <= csum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_r <= '0;
      idx_r  <= '0;
    end else begin
      if (cmd.build && func_r == fpd_pkg::FUNC_PCT) begin
        spin_r <= (spin_use == 4'(fpd_pkg::SPIN_STEPS - 1)) ? 4'd0 : spin_use + 4'd1;
      end
      if (cmd.send_adv) begin
        idx_r <= stat.last_byte ? '0 : idx_r + fpd_pkg::IDX_W'(1);
      end
    end
  end

  always_comb begin
    case (idx_r)
      3'd0:    out_frame_byte = fpd_pkg::HDR_BYTE;
      3'd1:    out_frame_byte = fpd_pkg::ZERO_BYTE;
      3'd2:    out_frame_byte = seg_r[0];
      3'd3:    out_frame_byte = seg_r[1];
      3'd4:    out_frame_byte = seg_r[2];
      3'd5:    out_frame_byte = seg_r[3];
      default: out_frame_byte = csum_r;
    endcase
  end

  assign out_frame_end = stat.last_byte;

endmodule
